>>> rtl/lru_stack_distance_top_macros.svh
// Assertion macros shared by the LRU stack-distance block.
`ifndef LRU_STACK_DISTANCE_TOP_MACROS_SVH
`define LRU_STACK_DISTANCE_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LSD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("LRU stack-distance check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define LSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("LRU stack-distance check failed");

`endif

>>> rtl/lsd_pkg.sv
// Package with sizes and control types of the LRU stack-distance block.
package lsd_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int PAGE_W     = 52;
  localparam int CFG_W      = 7;
  localparam int DEPTH_W    = 6;
  localparam int DEPTH_MAX  = (1 << DEPTH_W) - 1;
  localparam int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int COUNT_W    = $clog2(MAX_FRAMES + 1);
  localparam int CAP_RESET  = (64 > MAX_FRAMES) ? MAX_FRAMES : 64;

  // Per-cell control: capture a compare, apply an update, take the neighbor.
  typedef struct packed {
    logic cmp;
    logic upd;
    logic shift;
    logic valid;
  } lsd_cell_ctl_t;

  // Control from the sequencer to the stack.
  typedef struct packed {
    logic               cmp;
    logic               upd;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] upto;
  } lsd_stack_ctl_t;

endpackage

>>> rtl/lsd_cell.sv
// One entry of the recency stack with its own page comparator.
module lsd_cell (
  input  logic                        clk,
  input  lsd_pkg::lsd_cell_ctl_t      ctl,
  input  logic [lsd_pkg::PAGE_W-1:0]  page,
  input  logic [lsd_pkg::PAGE_W-1:0]  prev,
  output logic [lsd_pkg::PAGE_W-1:0]  entry,
  output logic                        match
);
  import lsd_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      match <= ctl.valid && (entry == page);
    end
    if (ctl.upd && ctl.shift) begin
      entry <= prev;
    end
  end

endmodule

>>> rtl/lsd_stack.sv
// Chain of stack cells with shift selection and hit position encoding.
module lsd_stack (
  input  logic                        clk,
  input  lsd_pkg::lsd_stack_ctl_t     ctl,
  input  logic [lsd_pkg::PAGE_W-1:0]  page_in,
  input  logic [lsd_pkg::PAGE_W-1:0]  front,
  output logic                        hit,
  output logic [lsd_pkg::IDX_W-1:0]   pos
);
  import lsd_pkg::*;

  logic [PAGE_W-1:0]     entries [MAX_FRAMES];
  logic [MAX_FRAMES-1:0] match_vec;
  lsd_cell_ctl_t         cell_ctl [MAX_FRAMES];

  assign hit = |match_vec;

  // Entries are unique, so at most one match bit is set.
  always_comb begin
    pos = '0;
    for (int k = 0; k < MAX_FRAMES; k++) begin
      if (match_vec[k]) begin
        pos = pos | IDX_W'(k);
      end
    end
  end

  // On a hit, cells up to the hit page take their neighbor's entry.
  // On a miss, cells up to the insertion limit do.
  always_comb begin
    for (int k = 0; k < MAX_FRAMES; k++) begin
      cell_ctl[k].cmp   = ctl.cmp;
      cell_ctl[k].upd   = ctl.upd;
      cell_ctl[k].valid = COUNT_W'(k) < ctl.count;
      if (k == 0) begin
        cell_ctl[k].shift = 1'b1;
      end else if (hit) begin
        cell_ctl[k].shift = |(match_vec >> k);
      end else begin
        cell_ctl[k].shift = COUNT_W'(k) <= ctl.upto;
      end
    end
  end

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    lsd_cell u_cell (
      .clk   (clk),
      .ctl   (cell_ctl[g]),
      .page  (page_in),
      .prev  ((g == 0) ? front : entries[(g == 0) ? 0 : g - 1]),
      .entry (entries[g]),
      .match (match_vec[g])
    );
  end

endmodule

>>> rtl/lru_stack_distance_top.sv
// Top level of the LRU stack-distance block: sequencer, counters and result register.
//
//   channel  direction  signals                         transfer when
//   input    in         in_valid in_ready page_number   in_valid && in_ready
//   result   out        out_valid out_ready hit depth   out_valid && out_ready
//   config   in         cfg_wr_en cfg_wr_data           cfg_wr_en high and stack empty
//
// Each page reference has two steps: in the transfer cycle every cell compares its
// entry with the page and registers a match bit; once the result register is free or
// draining, the match vector is encoded and the chain shifts. No new reference is taken
// until that update is done. A result waiting on a stalled output holds back only the
// update of the following reference, never its input transfer. Reset is synchronous
// and empties the stack at once; capacity returns to 64.
module lru_stack_distance_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [lsd_pkg::PAGE_W-1:0]  page_number,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        hit,
  output logic [lsd_pkg::DEPTH_W-1:0] depth,
  input  logic                        cfg_wr_en,
  input  logic [lsd_pkg::CFG_W-1:0]   cfg_wr_data
);
  import lsd_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] cap;
  logic [COUNT_W-1:0] cap_next;
  logic [COUNT_W-1:0] count_next;
  logic [DEPTH_W-1:0] depth_next;
  logic [PAGE_W-1:0]  page;
  lsd_stack_ctl_t     stack_ctl;
  logic               stack_hit;
  logic [IDX_W-1:0]   stack_pos;
  logic               accept;
  logic               go;
  logic               full;
  logic [31:0]        cfg_ext;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  // The update may only run when the result register is free or being drained.
  assign go       = (state == S_UPD) && (!out_valid || out_ready);
  assign full     = count >= cap;

  // Capacity is clamped into the range one to the number of frames.
  assign cfg_ext = {{(32 - CFG_W){1'b0}}, cfg_wr_data};
  always_comb begin
    if (cfg_ext == 32'd0) begin
      cap_next = COUNT_W'(1);
    end else if (cfg_ext > 32'(MAX_FRAMES)) begin
      cap_next = COUNT_W'(MAX_FRAMES);
    end else begin
      cap_next = COUNT_W'(cfg_ext);
    end
  end

  // A miss grows the stack until it is full; then the oldest page drops off.
  always_comb begin
    count_next = count;
    if (!stack_hit) begin
      count_next = full ? cap : count + COUNT_W'(1);
    end
  end

  // A miss reports depth zero; a deep hit saturates at the field maximum.
  always_comb begin
    if (!stack_hit) begin
      depth_next = '0;
    end else if (32'(stack_pos) > 32'(DEPTH_MAX)) begin
      depth_next = DEPTH_W'(DEPTH_MAX);
    end else begin
      depth_next = DEPTH_W'(stack_pos);
    end
  end

  assign stack_ctl.cmp   = accept;
  assign stack_ctl.upd   = go;
  assign stack_ctl.count = count;
  assign stack_ctl.upto  = full ? cap - COUNT_W'(1) : count;

  lsd_stack u_stack (
    .clk     (clk),
    .ctl     (stack_ctl),
    .page_in (page_number),
    .front   (page),
    .hit     (stack_hit),
    .pos     (stack_pos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      cap       <= COUNT_W'(CAP_RESET);
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en && (count == '0)) begin
        cap <= cap_next;
      end
      // A finished update refills the result register, even in the cycle it drains.
      if (go) begin
        out_valid <= 1'b1;
        hit       <= stack_hit;
        depth     <= depth_next;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          if (go) begin
            state <= S_IDLE;
            count <= count_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload register: the held page.
  always_ff @(posedge clk) begin
    if (accept) begin
      page <= page_number;
    end
  end

`include "lru_stack_distance_top_macros.svh"

  // The number of resident pages never passes the capacity.
  `LSD_ASSERT_IMPL(a_count_cap, 1'b1, count <= cap)
  // A hit depth always points inside the resident part of the stack.
  `LSD_ASSERT_IMPL(a_hit_depth, out_valid && hit, COUNT_W'(depth) < count)
  // A miss reports depth zero.
  `LSD_ASSERT_IMPL(a_miss_depth, out_valid && !hit, depth == '0)
  // Every update cycle leaves a result in the output register.
  `LSD_ASSERT_NEXT(a_result, go, out_valid && (state == S_IDLE))

endmodule
